[sv/sme_pkg.sv]
package sme_pkg;

  localparam int unsigned CmdW = 4;
  localparam int unsigned ErrW = 3;
  localparam int unsigned ImmW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_MOD   = 4'd4,
    CMD_AND   = 4'd5,
    CMD_OR    = 4'd6,
    CMD_NOT   = 4'd7,
    CMD_MIR   = 4'd8,
    CMD_POP   = 4'd9,
    CMD_OUT   = 4'd10,
    CMD_CLEAR = 4'd11,
    CMD_PUSH  = 4'd12
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 3'd0,
    ERR_POP_EMPTY = 3'd1,
    ERR_FULL      = 3'd2,
    ERR_FEW       = 3'd3,
    ERR_DIV_ZERO  = 3'd4
  } err_e;

endpackage

[sv/sme_ram.sv]
module sme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/stack_machine_execute.sv]
// channel | signals                                   | dir | beat taken when
// --------+-------------------------------------------+-----+--------------------------
// in      | in_valid_i, in_stall_o, cmd_i,            | in  | in_valid_i & !in_stall_o
//         | immediate_i, push_from_register_i         |     |
// out     | out_valid_o, out_stall_i, error_code_o,   | out | out_valid_o & !out_stall_i
//         | top_valid_o, top_value_o, result_value_o  |     |
//
// One instruction at a time. Pop, clear, push and early errors go straight to done;
// unary ops and out read T, binary ops read T and N, then execute; div and mod add the
// divider loop (one restoring step per cycle through the shared adder), the worst case.
// Stack words sit in a single-port-read RAM, so T and N are fetched on separate cycles.
// Reset empties the stack and clears R; stack RAM contents are not cleared.
// A stalled result holds the finished instruction in its last state until taken.
module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned WORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sme_pkg::CmdW-1:0]     cmd_i,
  input  logic signed [sme_pkg::ImmW-1:0] immediate_i,
  input  logic                         push_from_register_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sme_pkg::ErrW-1:0]     error_code_o,
  output logic                         top_valid_o,
  output logic signed [WORD_BITS-1:0]  top_value_o,
  output logic signed [WORD_BITS-1:0]  result_value_o
);

  import sme_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD_T = 7'b0000010,
    S_RD_N = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIX  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CmdW-1:0]  cmd_q;
  logic [W-1:0]     imm_q;
  logic             from_reg_q;
  err_e             err_q, err_d, err_acc;
  logic [W-1:0]     t_q, res_q, r_q, top_q, top_value_q;
  logic             upd_r_q, tv_q;
  logic [DW-1:0]    depth_q;
  logic [W-1:0]     quo_q, rem_q, dvs_q;
  logic             q_neg_q, r_neg_q;
  logic [CW-1:0]    cnt_q;
  logic             out_valid_q, top_valid_q;
  err_e             err_out_q;

  logic             accept, out_free, done_fire, is_bin, is_mod;
  logic [DW-1:0]    depth_m1, depth_m2;
  logic [AW-1:0]    raddr;
  logic [W-1:0]     rdata, op_t, op_n, mir_t, rem_shift, fix_x;
  logic [2*W-1:0]   prod;
  logic [W:0]       add_a, add_b, add_sum;
  logic             add_ci, fix_neg, ram_we;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign done_fire = (state_q == S_DONE) && out_free;
  assign is_bin    = cmd_q inside {[CMD_ADD:CMD_OR]};
  assign is_mod    = (cmd_q == CMD_MOD);
  assign depth_m1  = depth_q - DW'(1);
  assign depth_m2  = depth_q - DW'(2);
  assign raddr     = (state_q == S_RD_N) ? depth_m2[AW-1:0] : depth_m1[AW-1:0];
  assign op_t      = is_bin ? t_q : rdata;
  assign op_n      = rdata;
  assign prod      = op_t * op_n;
  assign rem_shift = {rem_q[W-2:0], quo_q[W-1]};
  assign fix_x     = is_mod ? rem_q : quo_q;
  assign fix_neg   = is_mod ? r_neg_q : q_neg_q;
  assign ram_we    = done_fire && (cmd_q == CMD_PUSH) && (err_q == ERR_OK);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mir_t[i] = op_t[W-1-i];
    end
  end

  // shared adder: add/sub, divider trial subtract, final sign fix
  always_comb begin
    add_a  = {1'b0, op_t};
    add_b  = {1'b0, op_n};
    add_ci = 1'b0;
    case (state_q)
      S_EXEC: begin
        if (cmd_q == CMD_SUB) begin
          add_b  = ~{1'b0, op_n};
          add_ci = 1'b1;
        end
      end
      S_DIV: begin
        add_a  = {1'b0, rem_shift};
        add_b  = ~{1'b0, dvs_q};
        add_ci = 1'b1;
      end
      S_FIX: begin
        add_a  = fix_neg ? '0 : {1'b0, fix_x};
        add_b  = fix_neg ? ~{1'b0, fix_x} : '0;
        add_ci = fix_neg;
      end
      default: begin
        add_a = {1'b0, op_t};
      end
    endcase
  end
  assign add_sum = add_a + add_b + (W+1)'(add_ci);

  always_comb begin
    err_acc = ERR_OK;
    if (cmd_i inside {[CMD_ADD:CMD_OR]}) begin
      if (depth_q < DW'(2)) err_acc = ERR_FEW;
    end else if (cmd_i == CMD_NOT || cmd_i == CMD_MIR) begin
      if (depth_q == '0) err_acc = ERR_FEW;
      else if (depth_q >= DW'(STACK_DEPTH)) err_acc = ERR_FULL;
    end else if (cmd_i == CMD_POP) begin
      if (depth_q == '0) err_acc = ERR_POP_EMPTY;
    end else if (cmd_i == CMD_OUT) begin
      if (depth_q == '0) err_acc = ERR_FEW;
    end else if (cmd_i == CMD_PUSH) begin
      if (depth_q >= DW'(STACK_DEPTH)) err_acc = ERR_FULL;
    end
  end

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          err_d = err_acc;
          if (err_acc != ERR_OK || !(cmd_i inside {[CMD_ADD:CMD_MIR], CMD_OUT})) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD_T;
          end
        end
      end
      S_RD_T: state_d = is_bin ? S_RD_N : S_EXEC;
      S_RD_N: state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q == CMD_DIV || cmd_q == CMD_MOD) begin
          if (op_n == '0) begin
            err_d   = ERR_DIV_ZERO;
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV:  if (cnt_q == '0) state_d = S_FIX;
      S_FIX:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= ERR_OK;
      depth_q     <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
      upd_r_q     <= 1'b0;
      tv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (accept) begin
        upd_r_q <= 1'b0;
        tv_q    <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        upd_r_q <= !(cmd_q inside {CMD_OUT, CMD_DIV, CMD_MOD});
        tv_q    <= (cmd_q == CMD_OUT);
      end
      if (state_q == S_FIX) begin
        upd_r_q <= 1'b1;
      end
      if (done_fire) begin
        if (upd_r_q) r_q <= res_q;
        if (err_q == ERR_OK) begin
          case (cmd_q)
            CMD_POP:   depth_q <= depth_m1;
            CMD_CLEAR: depth_q <= '0;
            CMD_PUSH:  depth_q <= depth_q + DW'(1);
            default:   depth_q <= depth_q;
          endcase
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      imm_q      <= W'(immediate_i);
      from_reg_q <= push_from_register_i;
    end
    if (state_q == S_RD_N) begin
      t_q <= rdata;
    end
    if (state_q == S_EXEC) begin
      top_q   <= op_t;
      q_neg_q <= op_t[W-1] ^ op_n[W-1];
      r_neg_q <= op_t[W-1];
      quo_q   <= op_t[W-1] ? W'(-op_t) : op_t;
      dvs_q   <= op_n[W-1] ? W'(-op_n) : op_n;
      rem_q   <= '0;
      cnt_q   <= CW'(W - 1);
      case (cmd_q)
        CMD_ADD, CMD_SUB: res_q <= add_sum[W-1:0];
        CMD_MUL:          res_q <= prod[W-1:0];
        CMD_AND:          res_q <= op_t & op_n;
        CMD_OR:           res_q <= op_t | op_n;
        CMD_NOT:          res_q <= ~op_t;
        CMD_MIR:          res_q <= mir_t;
        default:          res_q <= res_q;
      endcase
    end
    if (state_q == S_DIV) begin
      cnt_q <= cnt_q - CW'(1);
      if (!add_sum[W]) begin
        rem_q <= add_sum[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (state_q == S_FIX) begin
      res_q <= add_sum[W-1:0];
    end
    if (done_fire) begin
      err_out_q   <= err_q;
      top_valid_q <= tv_q && (err_q == ERR_OK);
      top_value_q <= (tv_q && (err_q == ERR_OK)) ? top_q : '0;
    end
  end

  sme_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(depth_q[AW-1:0]),
    .wdata_i(from_reg_q ? r_q : imm_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign error_code_o   = err_out_q;
  assign top_valid_o    = top_valid_q;
  assign top_value_o    = top_value_q;
  assign result_value_o = r_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("ready right after accepting a beat");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_top_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && top_valid_q |-> err_out_q == ERR_OK)
    else $error("top reported with an error");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> depth_q < DW'(STACK_DEPTH))
    else $error("stack write at capacity");

endmodule
